// File: sv/aes256_pkg.sv
// AES-256 package: beat structs, S-box tables and GF(2^8) helpers.
// Used by aes256_round and aes256_block_cipher; no dependencies.
package aes256_pkg;

    localparam int unsigned NumRounds = 14;
    localparam int unsigned KeyWords  = 8;
    localparam int unsigned SchedWords = 60;
    // one schedule word resolves per cycle after the key words load
    localparam int unsigned SettleCycles = SchedWords - KeyWords + 1;

    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        operation;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } aes_out_t;

    // per-stage control carried with the state
    typedef struct packed {
        logic valid;
        logic decrypt;
    } stage_ctl_t;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

    // byte n of the state is bits [127-8n -: 8]
    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv)
                    t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = s[127 - 8 * (4 * c + r) -: 8];
                else
                    t[127 - 8 * (4 * c + r) -: 8] = s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        t = '0;
        for (int n = 0; n < 16; n++) begin
            t[8 * n +: 8] = inv ? INV_SBOX[s[8 * n +: 8]] : FWD_SBOX[s[8 * n +: 8]];
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] o;
        for (int k = 0; k < 4; k++) begin
            a[k]  = c[31 - 8 * k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m2[k] = x2[k];
            m3[k] = x2[k] ^ a[k];
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        o = '0;
        for (int r = 0; r < 4; r++) begin
            if (inv)
                o[31 - 8 * r -: 8] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4] ^ m9[(r + 3) % 4];
            else
                o[31 - 8 * r -: 8] = m2[r] ^ m3[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            t[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32], inv);
        end
        return t;
    endfunction

endpackage

// File: sv/aes256_round.sv
// One registered AES round for either direction, inverse ordered as in the
// straight inverse cipher. Depends on aes256_pkg.
module aes256_round import aes256_pkg::*; #(
    parameter bit LastRound = 1'b0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  stage_ctl_t   ctl_in,
    input  logic [127:0] state_in,
    input  logic [127:0] enc_key,
    input  logic [127:0] dec_key,
    output stage_ctl_t   ctl_out,
    output logic [127:0] state_out
);

    stage_ctl_t   ctl_reg;
    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [127:0] enc_t;
    logic [127:0] dec_t;

    always_comb
    begin
        enc_t = shift_rows(sub_bytes(state_in, 1'b0), 1'b0);
        if (!LastRound)
            enc_t = mix_columns(enc_t, 1'b0);
        enc_t = enc_t ^ enc_key;
        dec_t = sub_bytes(shift_rows(state_in, 1'b1), 1'b1) ^ dec_key;
        if (!LastRound)
            dec_t = mix_columns(dec_t, 1'b1);
        state_next = ctl_in.decrypt ? dec_t : enc_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    // payload holds no reset
    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign ctl_out   = ctl_reg;
    assign state_out = state_reg;

endmodule

// File: sv/aes256_block_cipher.sv
// AES-256 ECB cipher: fully unrolled 14-round pipeline, one block per cycle while busy is low.
// Path from start to done: input key add register, 14 round registers, output register.
// Throughput: one beat per cycle once the key schedule has settled.
// The registered schedule resolves one word per cycle: busy holds high after reset and
// after every key write until the last word is valid. Reset clears key and valid bits.
module aes256_block_cipher import aes256_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  aes_in_t     din,
    output logic        done,
    output aes_out_t    dout,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]  key_reg [4];
    // schedule words, registered per step to keep key expansion shallow
    logic [31:0]  sched_reg [SchedWords];
    logic [31:0]  sched_next [SchedWords];
    logic [127:0] rk [NumRounds + 1];
    logic [5:0]   settle_reg;

    stage_ctl_t   ctl [NumRounds + 1];
    logic [127:0] st  [NumRounds + 1];
    stage_ctl_t   ctl0_reg;
    logic [127:0] st0_reg;
    logic         done_reg;
    logic [127:0] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_KEY0: key_reg[0] <= cfg_data;
                REG_KEY1: key_reg[1] <= cfg_data;
                REG_KEY2: key_reg[2] <= cfg_data;
                REG_KEY3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // hold off new beats until the last schedule word is valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= 6'(SettleCycles);
        else if (cfg_we)
            settle_reg <= 6'(SettleCycles);
        else if (settle_reg != '0)
            settle_reg <= settle_reg - 6'd1;
    end

    always_comb
    begin
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < KeyWords; i++) begin
            sched_next[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
        end
        for (int i = KeyWords; i < SchedWords; i++) begin
            t = sched_reg[i - 1];
            if (i % KeyWords == 0) begin
                t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = xtime(rc);
            end else if (i % KeyWords == 4) begin
                t = sub_word(t);
            end
            sched_next[i] = sched_reg[i - KeyWords] ^ t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < SchedWords; i++) sched_reg[i] <= '0;
        end else begin
            for (int i = 0; i < SchedWords; i++) sched_reg[i] <= sched_next[i];
        end
    end

    always_comb
    begin
        for (int r = 0; r <= NumRounds; r++) begin
            rk[r] = {sched_reg[4 * r], sched_reg[4 * r + 1], sched_reg[4 * r + 2],
                     sched_reg[4 * r + 3]};
        end
    end

    // input stage: first key add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl0_reg <= '0;
        else
            ctl0_reg <= '{valid: start & ~busy, decrypt: din.operation};
    end

    always_ff @(posedge clk)
    begin
        st0_reg <= {din.block_high, din.block_low} ^
                   (din.operation ? rk[NumRounds] : rk[0]);
    end

    assign ctl[0] = ctl0_reg;
    assign st[0]  = st0_reg;

    for (genvar g = 1; g <= NumRounds; g++) begin : g_round
        aes256_round #(
            .LastRound(g == NumRounds)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl[g - 1]),
            .state_in  (st[g - 1]),
            .enc_key   (rk[g]),
            .dec_key   (rk[NumRounds - g]),
            .ctl_out   (ctl[g]),
            .state_out (st[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl[NumRounds].valid;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= st[NumRounds];
    end

    assign busy = (settle_reg != '0);
    assign done = done_reg;
    assign dout = '{result_high: out_reg[127:64], result_low: out_reg[63:0]};

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl[NumRounds].valid |=> done)
        else $error("done lost after last round");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl[NumRounds].valid |=> !done)
        else $error("done without a beat");
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ctl[0].valid)
        else $error("accepted beat not in pipeline");
    a_key_write_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("beat accepted while schedule settles");

endmodule

// File: tb/aes256_block_cipher_test.sv
// Testbench for aes256_block_cipher: ECB encrypt/decrypt beats checked against
// a local AES-256 predictor. Depends on aes256_pkg types and the block's RTL.
`timescale 1ns / 100ps
module aes256_block_cipher_test;
    import aes256_pkg::*;

    localparam logic [7:0] SBOX_TBL [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    aes_in_t     din;
    logic        done;
    aes_out_t    dout;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    logic [63:0] key_regs [4];
    logic [7:0]  unsbox [256];
    logic [31:0] sched [60];

    aes_in_t  pending_blocks [$];
    int       pending_gaps [$];
    aes_out_t expected_blocks [$];
    int       gap_left;
    int       errors;
    bit       send_enable;

    aes256_block_cipher dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .din(din),
        .done(done), .dout(dout), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] gdbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int n = 0; n < 8; n++)
        begin
            if (b[n])
                acc ^= a;
            a = gdbl(a);
        end
        return acc;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {SBOX_TBL[w[31:24]], SBOX_TBL[w[23:16]], SBOX_TBL[w[15:8]], SBOX_TBL[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            sched[i] = (i % 2 == 0) ? key_regs[i / 2][63:32] : key_regs[i / 2][31:0];
        for (int i = 8; i < 60; i++)
        begin
            t = sched[i - 1];
            if (i % 8 == 0)
            begin
                t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gdbl(rc);
            end
            else if (i % 8 == 4)
                t = subst_word(t);
            sched[i] = sched[i - 8] ^ t;
        end
    endfunction

    // state bytes kept as s[0..15], column-major as in FIPS-197
    function automatic aes_out_t cipher_block(input aes_in_t b);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] col [4];
        logic [7:0] coef [4];
        logic [7:0] acc;
        logic       dec;
        int         rnd;
        aes_out_t   r;
        dec = b.operation;
        for (int n = 0; n < 8; n++)
        begin
            s[n]     = b.block_high[63 - 8 * n -: 8];
            s[8 + n] = b.block_low[63 - 8 * n -: 8];
        end
        if (dec)
        begin
            coef[0] = 8'd14;
            coef[1] = 8'd11;
            coef[2] = 8'd13;
            coef[3] = 8'd9;
        end
        else
        begin
            coef[0] = 8'd2;
            coef[1] = 8'd3;
            coef[2] = 8'd1;
            coef[3] = 8'd1;
        end
        for (int step = 0; step <= 14; step++)
        begin
            rnd = dec ? 14 - step : step;
            if (step > 0)
            begin
                if (!dec)
                begin
                    for (int n = 0; n < 16; n++)
                        s[n] = SBOX_TBL[s[n]];
                    t = s;
                    for (int c = 0; c < 4; c++)
                        for (int q = 0; q < 4; q++)
                            s[4 * c + q] = t[4 * ((c + q) % 4) + q];
                end
                else
                begin
                    t = s;
                    for (int c = 0; c < 4; c++)
                        for (int q = 0; q < 4; q++)
                            s[4 * ((c + q) % 4) + q] = t[4 * c + q];
                    for (int n = 0; n < 16; n++)
                        s[n] = unsbox[s[n]];
                end
            end
            // forward mixes before the key add, inverse after it
            if (!dec && step > 0 && step < 14)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    for (int k = 0; k < 4; k++)
                        col[k] = s[4 * c + k];
                    for (int q = 0; q < 4; q++)
                    begin
                        acc = '0;
                        for (int k = 0; k < 4; k++)
                            acc ^= gmul(col[k], coef[(k - q + 4) % 4]);
                        s[4 * c + q] = acc;
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    s[4 * c + q] ^= sched[4 * rnd + c][31 - 8 * q -: 8];
            if (dec && step > 0 && step < 14)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    for (int k = 0; k < 4; k++)
                        col[k] = s[4 * c + k];
                    for (int q = 0; q < 4; q++)
                    begin
                        acc = '0;
                        for (int k = 0; k < 4; k++)
                            acc ^= gmul(col[k], coef[(k - q + 4) % 4]);
                        s[4 * c + q] = acc;
                    end
                end
            end
        end
        for (int n = 0; n < 8; n++)
        begin
            r.result_high[63 - 8 * n -: 8] = s[n];
            r.result_low[63 - 8 * n -: 8]  = s[8 + n];
        end
        return r;
    endfunction

    // driver: hold each beat until accepted, then wait its drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            din      <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_blocks.push_back(cipher_block(din));
            end
            if (start && busy)
            begin
                // hold
            end
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (send_enable && pending_blocks.size() > 0)
            begin
                start    <= 1'b1;
                din      <= pending_blocks.pop_front();
                gap_left <= pending_gaps.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_blocks.size() == 0)
            begin
                $error("result beat with nothing expected: %h", dout);
                errors++;
            end
            else
            begin
                aes_out_t exp_blk;
                exp_blk = expected_blocks.pop_front();
                if (dout.result_high !== exp_blk.result_high)
                begin
                    $error("result_high expected %h actual %h",
                           exp_blk.result_high, dout.result_high);
                    errors++;
                end
                if (dout.result_low !== exp_blk.result_low)
                begin
                    $error("result_low expected %h actual %h",
                           exp_blk.result_low, dout.result_low);
                    errors++;
                end
            end
        end
    end

    task automatic queue_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        aes_in_t b;
        b.operation  = op;
        b.block_high = hi;
        b.block_low  = lo;
        pending_blocks.push_back(b);
        pending_gaps.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    endtask

    task automatic queue_burst(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        aes_in_t b;
        b.operation  = op;
        b.block_high = hi;
        b.block_low  = lo;
        pending_blocks.push_back(b);
        pending_gaps.push_back(0);
    endtask

    task automatic drain_all();
        send_enable = 1'b1;
        while (pending_blocks.size() > 0 || start || gap_left > 0 || expected_blocks.size() > 0)
            @(posedge clk);
        send_enable = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        key_regs[idx] = val;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h1;
            default: return rand64();
        endcase
    endfunction

    // load all four key words and mirror the schedule; the driver holds beats while busy
    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_key(REG_KEY0, k0);
        write_key(REG_KEY1, k1);
        write_key(REG_KEY2, k2);
        write_key(REG_KEY3, k3);
        repeat (DRAIN_CYCLES) @(posedge clk);
        expand_schedule();
    endtask

    initial
    begin
        int phases;
        int per_phase;
        aes_out_t ct;
        errors      = 0;
        send_enable = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_KEY0;
        cfg_data    = '0;
        for (int i = 0; i < 4; i++)
            key_regs[i] = '0;
        for (int i = 0; i < 256; i++)
            unsbox[SBOX_TBL[i]] = i[7:0];
        expand_schedule();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        // all-zero key straight out of reset
        queue_block(1'b0, 64'h0, 64'h0);
        queue_block(1'b1, 64'h0, 64'h0);
        queue_block(1'b0, '1, '1);
        drain_all();

        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        queue_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        queue_block(1'b0, '1, 64'h0);
        queue_block(1'b1, 64'h0, '1);
        queue_block(1'b0, 64'h8000000000000000, 64'h1);
        queue_block(1'b1, 64'h1, 64'h8000000000000000);
        for (int i = 0; i < 6; i++)
            queue_burst(i[0], rand64(), rand64());
        drain_all();

        load_key('1, '1, '1, '1);
        queue_block(1'b0, 64'h0, 64'h0);
        queue_block(1'b1, '1, '1);
        queue_block(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain_all();

        phases    = 8;
        per_phase = 240;
        for (int p = 0; p < phases; p++)
        begin
            if (p == 0)
                load_key(64'h0, 64'h0, 64'h0, 64'h0);
            else
                load_key(edge64(), edge64(), edge64(), edge64());
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    // round trip: encrypt, then decrypt the predicted ciphertext
                    aes_in_t pt;
                    pt.operation  = 1'b0;
                    pt.block_high = edge64();
                    pt.block_low  = edge64();
                    ct = cipher_block(pt);
                    queue_block(1'b0, pt.block_high, pt.block_low);
                    queue_block(1'b1, ct.result_high, ct.result_low);
                    i++;
                end
                else if (p % 3 == 2)
                    queue_burst(1'($urandom_range(0, 1)), rand64(), rand64());
                else
                    queue_block(1'($urandom_range(0, 1)), edge64(), edge64());
            end
            drain_all();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
sv/aes256_pkg.sv
sv/aes256_round.sv
sv/aes256_block_cipher.sv
tb/aes256_block_cipher_test.sv
